[rtl/core/nrbh_pkg.sv]
//------------------------------------------------------------------------------
// nrbh_pkg
// shared types and constants for the nearest ray-box hit block
//------------------------------------------------------------------------------
package nrbh_pkg;

    localparam int CoordW   = 32;
    localparam int DirW     = 18;
    localparam int IdxW     = 10;
    localparam int CfgIdxW  = 3;
    localparam int DefMaxBoxes = 1024;

    localparam logic signed [CoordW-1:0] TMinusOne = -32'sd65536;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_ORIGIN_Z = 3'd2,
        CFG_DIR_X    = 3'd3,
        CFG_DIR_Y    = 3'd4,
        CFG_DIR_Z    = 3'd5
    } t_cfg_idx;

    localparam logic [1:0] AXIS_INSIDE = 2'd3;

    // quadrant codes per axis
    typedef enum logic [1:0] {
        Q_ABOVE  = 2'd0,
        Q_BELOW  = 2'd1,
        Q_WITHIN = 2'd2
    } t_quad;

    // one classified box, handed from front to back
    typedef struct packed {
        logic signed [2:0][CoordW-1:0] bmin;
        logic signed [2:0][CoordW-1:0] bmax;
        logic signed [2:0][CoordW-1:0] plane;
        t_quad       [2:0]             quad;
        logic                          in_box;
        logic                          last;
    } t_box_word;

    typedef struct packed {
        logic                     hit;
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic signed [CoordW-1:0] z;
        logic [1:0]               axis;
        logic                     neg;
        logic [IdxW-1:0]          box;
    } t_result;

endpackage

[rtl/core/nrbh_front.sv]
//------------------------------------------------------------------------------
// nrbh_front
// accepts boxes, classifies each axis against the ray origin, feeds a queue
//------------------------------------------------------------------------------
module nrbh_front #(
    parameter int QDEPTH = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [2:0][nrbh_pkg::CoordW-1:0] i_origin,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [2:0][nrbh_pkg::CoordW-1:0] i_bmin,
    input  logic signed [2:0][nrbh_pkg::CoordW-1:0] i_bmax,
    input  logic                                i_last,
    output logic                                o_valid,
    input  logic                                i_ready,
    output nrbh_pkg::t_box_word                 o_word
);
    import nrbh_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    t_box_word         r_mem [QDEPTH];
    logic [PW-1:0]     r_wp, r_rp;
    logic [PW:0]       r_cnt;
    t_box_word         n_word;
    logic              w_push, w_pop;

    always_comb begin
        n_word        = '0;
        n_word.bmin   = i_bmin;
        n_word.bmax   = i_bmax;
        n_word.last   = i_last;
        n_word.in_box = 1'b1;
        for (int a = 0; a < 3; a++) begin
            if ($signed(i_origin[a]) < $signed(i_bmin[a])) begin
                n_word.quad[a]  = Q_BELOW;
                n_word.plane[a] = i_bmin[a];
                n_word.in_box   = 1'b0;
            end else if ($signed(i_origin[a]) > $signed(i_bmax[a])) begin
                n_word.quad[a]  = Q_ABOVE;
                n_word.plane[a] = i_bmax[a];
                n_word.in_box   = 1'b0;
            end else begin
                n_word.quad[a]  = Q_WITHIN;
            end
        end
    end

    assign o_ready = (r_cnt != (PW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_word  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= n_word;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PW'(QDEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PW'(QDEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(w_push) - (PW+1)'(w_pop);
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PW+1)'(QDEPTH)) else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == (PW+1)'(QDEPTH)) |-> !w_push) else $error("push while full");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("count step");

endmodule

[rtl/core/nrbh_div.sv]
//------------------------------------------------------------------------------
// nrbh_div
// radix-2 restoring divider, signed, truncating, saturated to 32 bits
//------------------------------------------------------------------------------
module nrbh_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [49:0]                i_num,
    input  logic signed [nrbh_pkg::DirW-1:0]  i_den,
    output logic                              o_done,
    output logic signed [nrbh_pkg::CoordW-1:0] o_quot
);
    import nrbh_pkg::*;

    // numerator magnitude fits 49 bits; 49 steps
    logic [48:0]  r_q;
    logic [17:0]  r_rem;
    logic [17:0]  r_d;
    logic         r_neg;
    logic [5:0]   r_step;
    logic         r_busy;
    logic [18:0]  w_trial;
    logic [17:0]  w_shift;

    assign w_shift = {r_rem[16:0], r_q[48]};
    assign w_trial = {1'b0, w_shift} - {1'b0, r_d};

    always_comb begin
        logic [49:0] mag;
        mag = r_neg ? -{1'b0, r_q} : {1'b0, r_q};
        if (!r_neg && r_q > 49'h0_7FFF_FFFF) begin
            o_quot = 32'sh7FFF_FFFF;
        end else if (r_neg && r_q > 49'h0_8000_0000) begin
            o_quot = 32'sh8000_0000;
        end else begin
            o_quot = mag[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_step <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 6'd0;
                r_q    <= i_num[49] ? 49'(-i_num) : 49'(i_num);
                r_d    <= i_den[DirW-1] ? 18'(-i_den) : 18'(i_den);
                r_neg  <= i_num[49] ^ i_den[DirW-1];
                r_rem  <= '0;
            end else if (r_busy) begin
                if (!w_trial[18]) begin
                    r_rem <= w_trial[17:0];
                    r_q   <= {r_q[47:0], 1'b1};
                end else begin
                    r_rem <= w_shift;
                    r_q   <= {r_q[47:0], 1'b0};
                end
                r_step <= r_step + 1'b1;
                if (r_step == 6'd48) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done not a pulse");
    a_done_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy)) else $error("done without work");
    a_busy_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start) |=> (r_step == $past(r_step) + 1'b1) || !r_busy)
        else $error("step skipped");

endmodule

[rtl/core/nrbh_back.sv]
//------------------------------------------------------------------------------
// nrbh_back
// per-box slab test sequencer, running nearest hit and result register
//------------------------------------------------------------------------------
module nrbh_back #(
    parameter int MAX_BOXES = nrbh_pkg::DefMaxBoxes
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic signed [2:0][nrbh_pkg::CoordW-1:0] i_origin,
    input  logic signed [2:0][nrbh_pkg::DirW-1:0]   i_dir,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  nrbh_pkg::t_box_word                     i_word,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output nrbh_pkg::t_result                       o_res
);
    import nrbh_pkg::*;

    localparam int CW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_PICK, S_MUL, S_CHK, S_UPD, S_OUT
    } t_state;

    t_state                    r_state;
    t_box_word                 r_w;
    logic [1:0]                r_ax;
    logic signed [CoordW-1:0]  r_t [3];
    logic [1:0]                r_win;
    logic signed [CoordW-1:0]  r_tw;
    logic signed [2:0][49:0]   r_prod;
    logic signed [2:0][CoordW-1:0] r_pt;
    logic                      r_hit;

    logic                      r_bfound;
    logic signed [CoordW-1:0]  r_bparam;
    logic signed [2:0][CoordW-1:0] r_bpt;
    logic [1:0]                r_baxis;
    logic                      r_bneg;
    logic [IdxW-1:0]           r_bbox;
    logic [CW-1:0]             r_cnt;

    logic                      w_start;
    logic signed [49:0]        w_num;
    logic                      w_done;
    logic signed [CoordW-1:0]  w_quot;
    logic                      w_divable;
    logic [IdxW-1:0]           w_cnt_idx;

    assign w_divable = (r_w.quad[r_ax] != Q_WITHIN) && (i_dir[r_ax] != '0);
    assign w_num     = (50'($signed(r_w.plane[r_ax])) - 50'($signed(i_origin[r_ax]))) <<< 16;
    assign w_cnt_idx = IdxW'({{IdxW{1'b0}}, r_cnt});

    nrbh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_num),
        .i_den   (i_dir[r_ax]),
        .o_done  (w_done),
        .o_quot  (w_quot)
    );

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        w_start = 1'b0;
        if (r_state == S_DIV && !r_hit && w_divable) begin
            w_start = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_bfound <= 1'b0;
            r_bparam <= '0;
            r_bpt    <= '0;
            r_baxis  <= '0;
            r_bneg   <= 1'b0;
            r_bbox   <= '0;
            r_cnt    <= '0;
            r_hit    <= 1'b0;
            o_res    <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_w   <= i_word;
                        r_ax  <= 2'd0;
                        r_hit <= 1'b0;
                        if (i_word.in_box) begin
                            r_pt    <= i_origin;
                            r_tw    <= '0;
                            r_win   <= AXIS_INSIDE;
                            r_state <= S_UPD;
                            r_hit   <= 1'b1;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    // r_hit marks a division in flight
                    if (!r_hit) begin
                        if (w_divable) begin
                            r_hit <= 1'b1;
                        end else begin
                            r_t[r_ax] <= TMinusOne;
                            if (r_ax == 2'd2) r_state <= S_PICK;
                            r_ax <= r_ax + 1'b1;
                        end
                    end else if (w_done) begin
                        r_hit     <= 1'b0;
                        r_t[r_ax] <= w_quot;
                        if (r_ax == 2'd2) r_state <= S_PICK;
                        r_ax <= r_ax + 1'b1;
                    end
                end
                S_PICK: begin
                    logic [1:0] w;
                    w = 2'd0;
                    if (r_t[0] < r_t[1]) w = 2'd1;
                    if (r_t[w] < r_t[2]) w = 2'd2;
                    r_win <= w;
                    r_tw  <= r_t[w];
                    if (r_t[w] < 0) begin
                        r_hit   <= 1'b0;
                        r_state <= S_UPD;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    for (int a = 0; a < 3; a++) begin
                        r_prod[a] <= 50'(r_tw) * 50'($signed(i_dir[a]));
                    end
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    logic h;
                    logic signed [49:0] c;
                    h = 1'b1;
                    for (int a = 0; a < 3; a++) begin
                        c = 50'($signed(i_origin[a])) + ($signed(r_prod[a]) >>> 16);
                        if (a == r_win) begin
                            r_pt[a] <= r_w.plane[a];
                        end else begin
                            r_pt[a] <= c[CoordW-1:0];
                            if (c < 50'($signed(r_w.bmin[a])) ||
                                c > 50'($signed(r_w.bmax[a]))) h = 1'b0;
                        end
                    end
                    r_hit   <= h;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    logic      take;
                    logic      neg;
                    take = r_hit && (!r_bfound || r_tw < r_bparam);
                    neg  = (r_win != AXIS_INSIDE) && (r_w.quad[r_win] == Q_BELOW);
                    r_hit <= 1'b0;
                    if (r_w.last) begin
                        o_res.hit  <= r_bfound || take;
                        o_res.x    <= take ? r_pt[0] : (r_bfound ? r_bpt[0] : '0);
                        o_res.y    <= take ? r_pt[1] : (r_bfound ? r_bpt[1] : '0);
                        o_res.z    <= take ? r_pt[2] : (r_bfound ? r_bpt[2] : '0);
                        o_res.axis <= take ? r_win : (r_bfound ? r_baxis : 2'd0);
                        o_res.neg  <= take ? neg : (r_bfound && r_bneg);
                        o_res.box  <= take ? w_cnt_idx : (r_bfound ? r_bbox : '0);
                        r_bfound   <= 1'b0;
                        r_cnt      <= '0;
                        r_state    <= S_OUT;
                    end else begin
                        if (take) begin
                            r_bfound <= 1'b1;
                            r_bparam <= r_tw;
                            r_bpt    <= r_pt;
                            r_baxis  <= r_win;
                            r_bneg   <= neg;
                            r_bbox   <= w_cnt_idx;
                        end
                        r_cnt   <= (r_cnt == CW'(MAX_BOXES-1)) ? '0 : r_cnt + 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid && $stable(o_res)) else $error("result lost");
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && r_w.last) |=> !r_bfound && r_cnt == '0)
        else $error("best not cleared");
    a_nohit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_res.hit) |-> o_res.box == '0 && o_res.axis == 2'd0)
        else $error("no-hit fields nonzero");

endmodule

[rtl/core/nearest_ray_box_hit.sv]
//------------------------------------------------------------------------------
// nearest_ray_box_hit
// nearest hit of a configured ray against a stream of axis-aligned boxes
//------------------------------------------------------------------------------
// usage: write origin and direction through the config port while idle, then
// stream boxes on the input channel (valid/ready). each box is classified in
// the front stage and queued; the back stage runs up to three serial
// divisions on one shared radix-2 divider, then a multiply and a bounds
// check. the back stage goes straight to the update when the origin is
// inside a box and starts no division when no axis needs one; it takes a
// new box from the queue only once it is through with the last.
// the word flagged last_box produces one result word on the output channel
// holding the nearest hit (or zeros if none); other boxes produce none.
// the result stays valid and stable while the receiver stalls, and the queue
// keeps taking boxes until full. reset is synchronous, active low: it clears
// the ray registers, the running best and the box counter.
//------------------------------------------------------------------------------
module nearest_ray_box_hit #(
    parameter int MAX_BOXES = nrbh_pkg::DefMaxBoxes
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [nrbh_pkg::CfgIdxW-1:0]         i_cfg_idx,
    input  logic [nrbh_pkg::CoordW-1:0]          i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [nrbh_pkg::CoordW-1:0]   i_box_min_x,
    input  logic signed [nrbh_pkg::CoordW-1:0]   i_box_min_y,
    input  logic signed [nrbh_pkg::CoordW-1:0]   i_box_min_z,
    input  logic signed [nrbh_pkg::CoordW-1:0]   i_box_max_x,
    input  logic signed [nrbh_pkg::CoordW-1:0]   i_box_max_y,
    input  logic signed [nrbh_pkg::CoordW-1:0]   i_box_max_z,
    input  logic                                 i_last_box,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_hit,
    output logic signed [nrbh_pkg::CoordW-1:0]   o_hit_x,
    output logic signed [nrbh_pkg::CoordW-1:0]   o_hit_y,
    output logic signed [nrbh_pkg::CoordW-1:0]   o_hit_z,
    output logic [1:0]                           o_face_axis,
    output logic                                 o_normal_negative,
    output logic [nrbh_pkg::IdxW-1:0]            o_box_index
);
    import nrbh_pkg::*;

    logic signed [2:0][CoordW-1:0] r_origin;
    logic signed [2:0][DirW-1:0]   r_dir;
    logic                          w_qv, w_qr;
    t_box_word                     w_word;
    t_result                       w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin <= '0;
            r_dir    <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ORIGIN_X: r_origin[0] <= i_cfg_data;
                CFG_ORIGIN_Y: r_origin[1] <= i_cfg_data;
                CFG_ORIGIN_Z: r_origin[2] <= i_cfg_data;
                CFG_DIR_X:    r_dir[0]    <= i_cfg_data[DirW-1:0];
                CFG_DIR_Y:    r_dir[1]    <= i_cfg_data[DirW-1:0];
                CFG_DIR_Z:    r_dir[2]    <= i_cfg_data[DirW-1:0];
                default: ;
            endcase
        end
    end

    nrbh_front #(.QDEPTH(2)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_origin (r_origin),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_bmin   ({i_box_min_z, i_box_min_y, i_box_min_x}),
        .i_bmax   ({i_box_max_z, i_box_max_y, i_box_max_x}),
        .i_last   (i_last_box),
        .o_valid  (w_qv),
        .i_ready  (w_qr),
        .o_word   (w_word)
    );

    nrbh_back #(.MAX_BOXES(MAX_BOXES)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_origin (r_origin),
        .i_dir    (r_dir),
        .i_valid  (w_qv),
        .o_ready  (w_qr),
        .i_word   (w_word),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_res    (w_res)
    );

    assign o_hit             = w_res.hit;
    assign o_hit_x           = w_res.x;
    assign o_hit_y           = w_res.y;
    assign o_hit_z           = w_res.z;
    assign o_face_axis       = w_res.axis;
    assign o_normal_negative = w_res.neg;
    assign o_box_index       = w_res.box;

endmodule

[test/nearest_ray_box_hit_test.sv]
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// nearest_ray_box_hit_test
// streams box sets against several configured rays and compares each result
// word with an in-bench model of the nearest-hit search
//------------------------------------------------------------------------------
module nearest_ray_box_hit_test;
    import nrbh_pkg::*;

    typedef struct packed {
        logic signed [31:0] mnx, mny, mnz, mxx, mxy, mxz;
        logic               last;
    } t_box;

    typedef struct {
        t_box    box;
        logic    known;
        t_result res;
    } t_row;

    localparam longint TMax = 64'sd2147483647;
    localparam longint TMin = -64'sd2147483648;

    logic i_clk = 0, i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [CfgIdxW-1:0] i_cfg_idx = '0;
    logic [CoordW-1:0] i_cfg_data = '0;
    logic i_valid = 0, i_ready = 0, i_last_box = 0;
    logic signed [31:0] i_box_min_x = 0, i_box_min_y = 0, i_box_min_z = 0;
    logic signed [31:0] i_box_max_x = 0, i_box_max_y = 0, i_box_max_z = 0;
    logic o_ready, o_valid, o_hit, o_normal_negative;
    logic signed [31:0] o_hit_x, o_hit_y, o_hit_z;
    logic [1:0] o_face_axis;
    logic [IdxW-1:0] o_box_index;

    nearest_ray_box_hit dut (.*);

    always #6 i_clk = ~i_clk;

    longint ray_org[3], ray_dir[3];
    logic best_found;
    longint best_t, best_pt[3];
    logic [1:0] best_axis;
    logic best_neg;
    logic [9:0] best_box, box_count;
    t_result hits_due[$];
    t_result forced_due[$];
    logic forced_known[$];
    t_row rows[$];
    int errors = 0;
    int hold_off = 0;
    logic long_hold = 0, long_hold_done = 0;

    function automatic longint floor16(longint x);
        if (x >= 0) return x / 65536;
        return -((-x + 65535) / 65536);
    endfunction

    task automatic add_row(t_box b, logic known, t_result r);
        t_row w;
        w.box = b; w.known = known; w.res = r;
        rows = {rows, w};
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we = 1; i_cfg_idx = idx; i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 0;
        if (idx < CFG_DIR_X) ray_org[idx] = longint'(signed'(val));
        else ray_dir[idx - CFG_DIR_X] = longint'(signed'(val[17:0]));
    endtask

    task automatic set_ray(logic [31:0] o[3], logic [17:0] d[3]);
        write_reg(CFG_ORIGIN_X, o[0]); write_reg(CFG_ORIGIN_Y, o[1]);
        write_reg(CFG_ORIGIN_Z, o[2]);
        write_reg(CFG_DIR_X, {{14{d[0][17]}}, d[0]});
        write_reg(CFG_DIR_Y, {{14{d[1][17]}}, d[1]});
        write_reg(CFG_DIR_Z, {{14{d[2][17]}}, d[2]});
    endtask

    // nearest-hit model for one accepted box
    task automatic trace_box(t_box b, logic known, t_result given);
        longint lo[3], hi[3], pl[3], t[3], pt[3], prm, v;
        int q[3], w;
        logic ins, hit;
        t_result r;
        lo = '{b.mnx, b.mny, b.mnz}; hi = '{b.mxx, b.mxy, b.mxz};
        ins = 1; hit = 1; prm = 0; w = 3;
        for (int i = 0; i < 3; i++) begin
            pl[i] = 0; q[i] = Q_WITHIN;
            if (ray_org[i] < lo[i]) begin
                q[i] = Q_BELOW; pl[i] = lo[i]; ins = 0;
            end else if (ray_org[i] > hi[i]) begin
                q[i] = Q_ABOVE; pl[i] = hi[i]; ins = 0;
            end
        end
        if (ins) begin
            for (int i = 0; i < 3; i++) pt[i] = ray_org[i];
        end else begin
            for (int i = 0; i < 3; i++) begin
                if (q[i] != Q_WITHIN && ray_dir[i] != 0) begin
                    v = ((pl[i] - ray_org[i]) * 65536) / ray_dir[i];
                    t[i] = v > TMax ? TMax : v < TMin ? TMin : v;
                end else begin
                    t[i] = -65536;
                end
            end
            w = 0;
            for (int i = 1; i < 3; i++) if (t[w] < t[i]) w = i;
            if (t[w] < 0) begin
                hit = 0;
            end else begin
                for (int i = 0; i < 3; i++) begin
                    if (i != w) begin
                        pt[i] = ray_org[i] + floor16(t[w] * ray_dir[i]);
                        if (pt[i] < lo[i] || pt[i] > hi[i]) hit = 0;
                    end else begin
                        pt[i] = pl[i];
                    end
                end
                prm = t[w];
            end
        end
        if (hit && (!best_found || prm < best_t)) begin
            best_found = 1; best_t = prm; best_pt = pt;
            best_axis = 2'(w); best_neg = !ins && q[w] == Q_BELOW; best_box = box_count;
        end
        box_count++;
        if (b.last) begin
            r = '0;
            if (best_found) begin
                r.hit = 1; r.x = 32'(best_pt[0]); r.y = 32'(best_pt[1]);
                r.z = 32'(best_pt[2]);
                r.axis = best_axis; r.neg = best_neg; r.box = best_box;
            end
            hits_due = {hits_due, r};
            forced_known = {forced_known, known};
            forced_due = {forced_due, given};
            best_found = 0; best_t = 0; best_pt = '{0, 0, 0};
            best_axis = 0; best_neg = 0; best_box = 0; box_count = 0;
        end
    endtask

    task automatic send_box(t_box b, logic known = 0, t_result given = '0);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(negedge i_clk);
        i_valid = 1;
        {i_box_min_x, i_box_min_y, i_box_min_z, i_box_max_x, i_box_max_y, i_box_max_z,
         i_last_box} = b;
        do @(posedge i_clk); while (!o_ready);
        trace_box(b, known, given);
        @(negedge i_clk);
        i_valid = 0;
    endtask

    task automatic drain;
        while (hits_due.size() != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord(int spread);
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return $urandom_range(0, spread) - spread / 2;
        endcase
    endfunction

    function automatic t_box rand_box(int spread);
        t_box b;
        logic [31:0] a, c;
        b.last = 0;
        a = rand_coord(spread); c = rand_coord(spread);
        if ($urandom_range(0, 9) != 0 && $signed(a) > $signed(c)) {a, c} = {c, a};
        b.mnx = a; b.mxx = c;
        a = rand_coord(spread); c = rand_coord(spread);
        if ($urandom_range(0, 9) != 0 && $signed(a) > $signed(c)) {a, c} = {c, a};
        b.mny = a; b.mxy = c;
        a = rand_coord(spread); c = rand_coord(spread);
        if ($urandom_range(0, 9) != 0 && $signed(a) > $signed(c)) {a, c} = {c, a};
        b.mnz = a; b.mxz = c;
        return b;
    endfunction

    // result side: random stall, one long hold-off
    always @(negedge i_clk) begin
        if (long_hold && !long_hold_done) begin
            i_ready <= 0;
            hold_off <= 5000;
            long_hold_done <= 1;
        end else if (hold_off > 0) begin
            i_ready <= 0;
            hold_off <= hold_off - 1;
        end else if ($urandom_range(0, 9) == 0) begin
            i_ready <= 0;
            hold_off <= $urandom_range(0, 3) == 0 ? $urandom_range(10, 60) : 0;
        end else begin
            i_ready <= $urandom_range(0, 3) != 0;
        end
    end

    always @(posedge i_clk) begin
        t_result got, want;
        logic known;
        t_result given;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_hit, o_hit_x, o_hit_y, o_hit_z, o_face_axis, o_normal_negative,
                    o_box_index};
            if (hits_due.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                want = hits_due.pop_front();
                known = forced_known.pop_front();
                given = forced_due.pop_front();
                if (known && given != want) begin
                    $error("table row disagrees with model: %h vs %h", given, want);
                    errors++;
                end
                if (got.hit != want.hit) begin
                    $error("hit exp %0d got %0d", want.hit, got.hit); errors++;
                end
                if (got.x != want.x) begin
                    $error("hit_x exp %0d got %0d", want.x, got.x); errors++;
                end
                if (got.y != want.y) begin
                    $error("hit_y exp %0d got %0d", want.y, got.y); errors++;
                end
                if (got.z != want.z) begin
                    $error("hit_z exp %0d got %0d", want.z, got.z); errors++;
                end
                if (got.axis != want.axis) begin
                    $error("face_axis exp %0d got %0d", want.axis, got.axis); errors++;
                end
                if (got.neg != want.neg) begin
                    $error("normal_negative exp %0d got %0d", want.neg, got.neg); errors++;
                end
                if (got.box != want.box) begin
                    $error("box_index exp %0d got %0d", want.box, got.box); errors++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    localparam logic [31:0] ONE = 32'h10000;

    initial begin
        t_box b;
        t_result r;
        logic [31:0] o[3];
        logic [17:0] d[3];
        int n, set_len, spread;
        ray_org = '{0, 0, 0}; ray_dir = '{0, 0, 0};
        best_found = 0; best_t = 0; best_pt = '{0, 0, 0};
        best_axis = 0; best_neg = 0; best_box = 0; box_count = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // after reset: zero ray, origin inside the unit box
        r = '{1, 0, 0, 0, AXIS_INSIDE, 0, 0};
        add_row('{-ONE, -ONE, -ONE, ONE, ONE, ONE, 1}, 1, r);
        // zero direction never reaches a box outside
        add_row('{ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, 1}, 1, '0);
        // extremes of box fields, inverted box
        add_row('{32'h80000000, 32'h80000000, 32'h80000000,
                  32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0}, 0, '0);
        add_row('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                  32'h80000000, 32'h80000000, 32'h80000000, 1}, 0, '0);
        foreach (rows[i]) send_box(rows[i].box, rows[i].known, rows[i].res);
        drain();

        // ray along +x, boxes ahead and behind, ties, saturation
        o = '{-10 * ONE, 0, 0}; d = '{18'h10000, 0, 0};
        set_ray(o, d);
        rows.delete();
        add_row('{5 * ONE, -ONE, -ONE, 6 * ONE, ONE, ONE, 0}, 0, '0);
        add_row('{2 * ONE, -ONE, -ONE, 3 * ONE, ONE, ONE, 0}, 0, '0);
        add_row('{2 * ONE, -ONE, -ONE, 4 * ONE, ONE, ONE, 0}, 0, '0);
        add_row('{-20 * ONE, -ONE, -ONE, -15 * ONE, ONE, ONE, 0}, 0, '0);
        add_row('{32'h7fff0000, -ONE, -ONE, 32'h7fffffff, ONE, ONE, 1}, 0, '0);
        foreach (rows[i]) send_box(rows[i].box);
        drain();

        o = '{ONE, 32'h7fffffff, 32'h80000000};
        d = '{18'h30000, 18'h1ffff, 18'h20000};
        set_ray(o, d);
        rows.delete();
        add_row('{-4 * ONE, 0, 32'h80000000, 0, 32'h7fffffff, 0, 0}, 0, '0);
        add_row('{0, 0, 0, ONE, ONE, ONE, 1}, 0, '0);
        foreach (rows[i]) send_box(rows[i].box);
        drain();

        // random phases with varied rays
        n = 0;
        while (n < 450) begin
            spread = ($urandom_range(0, 3) == 0) ? 32'h7fffffff : 64 * ONE;
            for (int i = 0; i < 3; i++) begin
                o[i] = ($urandom_range(0, 4) == 0) ? $urandom
                                                   : $urandom_range(0, 32 * ONE) - 16 * ONE;
                case ($urandom_range(0, 5))
                    0: d[i] = 0;
                    1: d[i] = $urandom;
                    2: d[i] = $urandom_range(0, 1) ? 18'h10000 : 18'h30000;
                    default: d[i] = $urandom_range(0, 2 * ONE) - ONE;
                endcase
            end
            set_ray(o, d);
            for (int s = 0; s < 8 && n < 450; s++) begin
                set_len = $urandom_range(0, 5) == 0 ? $urandom_range(10, 20)
                                                    : $urandom_range(1, 5);
                if (n >= 200 && s == 0) long_hold = 1;
                for (int k = 0; k < set_len; k++) begin
                    b = rand_box(spread);
                    b.last = (k == set_len - 1);
                    send_box(b);
                    n++;
                end
                if ($urandom_range(0, 5) == 0 && hold_off == 0) drain();
            end
            drain();
        end
        drain();
        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule

[nearest_ray_box_hit.f]
rtl/core/nrbh_pkg.sv
rtl/core/nrbh_front.sv
rtl/core/nrbh_div.sv
rtl/core/nrbh_back.sv
rtl/core/nearest_ray_box_hit.sv
test/nearest_ray_box_hit_test.sv
